>>> rtl/core/clti_pkg.sv
// ----------------------------------------------------------------------------
// clti_pkg
// Shared constants and types of the core-local timer and interrupt block.
// ----------------------------------------------------------------------------
`default_nettype none

package clti_pkg;

  // Hart count and the index width that follows from it
  localparam int HARTS     = 4;
  localparam int HART_W    = (HARTS > 1) ? $clog2(HARTS) : 1;
  // Harts whose levels reach the result beat
  localparam int IRQ_HARTS = (HARTS < 4) ? HARTS : 4;

  // Register map
  localparam logic [15:0] SOFT_END  = 16'h4000;
  localparam logic [15:0] TIMER_OFF = 16'hBFF8;
  localparam logic [15:0] MAP_END   = 16'hC000;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADD,
    S_ACC,
    S_RDATA,
    S_CMP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_SOFT,
    SRC_TIMER,
    SRC_CMP
  } src_t;

endpackage

`default_nettype wire

>>> rtl/core/clti_ram.sv
// ----------------------------------------------------------------------------
// clti_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module clti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          addr,
  input  wire logic [WIDTH-1:0]       wdata,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/core_local_timer_interruptor_unit.sv
// ----------------------------------------------------------------------------
// core_local_timer_interruptor_unit
// Core-local timer and software interrupt block: 64-bit timer, one 64-bit
// compare and one software bit per hart, driven by tick, read and write beats.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+----------------------------------
//  in_     | sink      | tvalid/tready      | tuser mode, tdata access + tick
//  out_    | source    | tvalid/tready      | tdata read result + irq levels
//  cfg_    | sink      | we (no wait)       | wdata tick divisor
//
//  A tick beat runs the serial divider one quotient bit per cycle: accept,
//  the divide steps, the add, a compare sweep over the single compare RAM
//  port and the result state. A read or write beat goes through accept,
//  access, read data, the compare sweep and the result state.
//  Reset (rst_n low, synchronous) clears the timer, soft bits, compare valid
//  bits (an invalid compare reads as all ones) and sets the divisor to one.
//  A new beat is taken while the last result still waits in the output
//  register; the block holds in its result state until that slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module core_local_timer_interruptor_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // cfg: tick_divisor
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  // in
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,   // [1:0] mode
  // [15:0] offset, [19:16] access_bytes, [83:20] write_data,
  // [115:84] tick_count, [119:116] zero
  input  wire logic [119:0] in_tdata,
  // out
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [63:0] read_data, [64] read_ok, [65] divisor_error, [69:66] soft_irq,
  // [73:70] timer_irq, [79:74] zero
  output logic [79:0]       out_tdata
);

  // Control state
  clti_pkg::state_t             state_r, state_nxt;
  logic [clti_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [63:0]                  timer_r, timer_nxt;
  logic [clti_pkg::HARTS-1:0]   soft_r, soft_nxt;
  logic [clti_pkg::HARTS-1:0]   cmp_valid_r, cmp_valid_nxt;
  logic [15:0]                  cfg_div_r;
  logic [3:0]                   tirq_r, tirq_nxt;

  // Item payload and datapath
  logic [1:0]                   mode_r;
  logic [15:0]                  off_r;
  logic [3:0]                   nb_r;
  logic [63:0]                  wdata_r;
  logic [31:0]                  cnt_r, cnt_nxt;     // dividend in, quotient out
  logic [15:0]                  rem_r, rem_nxt;
  logic [63:0]                  rdata_r, rdata_nxt;
  logic                         ok_r, ok_nxt;
  logic                         err_r, err_nxt;
  clti_pkg::src_t               src_r, src_nxt;
  logic [1:0]                   slot_r, slot_nxt;
  logic [clti_pkg::HART_W-1:0]  rd_hart_r;
  logic [79:0]                  out_data_r, out_data_nxt;

  // Compare RAM port
  logic                         ram_we;
  logic [clti_pkg::HART_W-1:0]  ram_addr;
  logic [63:0]                  ram_rdata;
  logic [63:0]                  cmp_eff;

  // Divider step
  logic [15:0]                  div_eff;
  logic [16:0]                  trial;
  logic                         qbit;

  // Address decode
  logic                         in_map;
  logic                         is_soft;
  logic                         is_timer;
  logic [13:0]                  soft_h;
  logic [15:0]                  cmp_rel;
  logic [12:0]                  cmp_h;
  logic                         soft_hit;
  logic                         cmp_hit;
  logic                         rd_ok;
  clti_pkg::src_t               rd_src;
  logic [3:0]                   soft4;
  logic [clti_pkg::HARTS+3:0]   soft_ext;
  logic [63:0]                  rd_val;

  // Byte mask for the access length; lengths above eight take all bytes
  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nb) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  clti_ram #(
    .WIDTH (64),
    .DEPTH (clti_pkg::HARTS)
  ) u_cmp_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wdata_r),
    .rdata (ram_rdata)
  );

  // A divisor of zero acts as one
  assign div_eff = (cfg_div_r == 16'd0) ? 16'd1 : cfg_div_r;
  assign trial   = {rem_r, cnt_r[31]};
  assign qbit    = (trial >= {1'b0, div_eff});

  // Decode the held offset
  assign in_map   = (off_r < clti_pkg::MAP_END);
  assign is_soft  = (off_r < clti_pkg::SOFT_END);
  assign is_timer = (off_r == clti_pkg::TIMER_OFF);
  assign soft_h   = off_r[15:2];
  assign cmp_rel  = off_r - clti_pkg::SOFT_END;
  assign cmp_h    = cmp_rel[15:3];
  assign soft_hit = (32'(soft_h) < clti_pkg::HARTS);
  assign cmp_hit  = (32'(cmp_h) < clti_pkg::HARTS);

  // Misaligned soft or compare reads are refused; the timer word is aligned
  assign rd_ok = in_map && (is_soft ? (off_r[1:0] == 2'b00)
                                    : (is_timer || (off_r[2:0] == 3'b000)));

  always_comb begin
    if (is_soft) begin
      rd_src = soft_hit ? clti_pkg::SRC_SOFT : clti_pkg::SRC_ZERO;
    end else if (is_timer) begin
      rd_src = clti_pkg::SRC_TIMER;
    end else begin
      rd_src = cmp_hit ? clti_pkg::SRC_CMP : clti_pkg::SRC_ZERO;
    end
  end

  // A compare never written reads as all ones
  assign cmp_eff = cmp_valid_r[rd_hart_r] ? ram_rdata : '1;

  // Soft levels of the reported harts, zero above HARTS
  assign soft_ext = {4'b0000, soft_r};
  assign soft4    = soft_ext[3:0];

  always_comb begin
    case (src_r)
      clti_pkg::SRC_SOFT:  rd_val = 64'(soft_r[clti_pkg::HART_W'(soft_h)]);
      clti_pkg::SRC_TIMER: rd_val = timer_r;
      clti_pkg::SRC_CMP:   rd_val = cmp_eff;
      default:             rd_val = '0;
    endcase
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    timer_nxt     = timer_r;
    soft_nxt      = soft_r;
    cmp_valid_nxt = cmp_valid_r;
    tirq_nxt      = tirq_r;
    rdata_nxt     = rdata_r;
    ok_nxt        = ok_r;
    err_nxt       = err_r;
    src_nxt       = src_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_addr      = '0;
    in_tready     = (state_r == clti_pkg::S_IDLE);

    case (state_r)
      clti_pkg::S_IDLE: begin
        // Take a beat; start the divider for ticks, else go decode
        if (in_tvalid) begin
          rdata_nxt = '0;
          ok_nxt    = 1'b0;
          err_nxt   = 1'b0;
          src_nxt   = clti_pkg::SRC_ZERO;
          step_nxt  = '0;
          rem_nxt   = '0;
          cnt_nxt   = in_tdata[115:84];
          if (in_tuser == clti_pkg::MODE_TICK) begin
            state_nxt = clti_pkg::S_DIV;
          end else begin
            state_nxt = clti_pkg::S_ACC;
          end
        end
      end

      clti_pkg::S_DIV: begin
        // Restoring division: shift in one dividend bit, shift out one
        // quotient bit
        if (qbit) begin
          rem_nxt = 16'(trial - {1'b0, div_eff});
        end else begin
          rem_nxt = trial[15:0];
        end
        cnt_nxt  = {cnt_r[30:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == clti_pkg::STEP_W'(clti_pkg::DIV_STEPS - 1)) begin
          state_nxt = clti_pkg::S_ADD;
        end
      end

      clti_pkg::S_ADD: begin
        // Advance the timer by the quotient; a remainder flags the error
        timer_nxt = timer_r + 64'(cnt_r);
        err_nxt   = (rem_r != 16'd0);
        step_nxt  = '0;
        state_nxt = clti_pkg::S_CMP;
      end

      clti_pkg::S_ACC: begin
        ram_addr = clti_pkg::HART_W'(cmp_h);
        case (mode_r)
          clti_pkg::MODE_READ: begin
            ok_nxt  = rd_ok;
            src_nxt = rd_src;
          end
          clti_pkg::MODE_WRITE: begin
            if (in_map) begin
              if (is_soft) begin
                if ((off_r[1:0] == 2'b00) && (nb_r >= 4'd4) && soft_hit) begin
                  soft_nxt[clti_pkg::HART_W'(soft_h)] = wdata_r[0];
                end
              end else if ((nb_r == 4'd8) && (off_r[2:0] == 3'b000)) begin
                if (is_timer) begin
                  timer_nxt = wdata_r;
                end else if (cmp_hit) begin
                  ram_we = 1'b1;
                  cmp_valid_nxt[clti_pkg::HART_W'(cmp_h)] = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase
        state_nxt = clti_pkg::S_RDATA;
      end

      clti_pkg::S_RDATA: begin
        // Compare RAM data for the read is out now; cut to length
        if ((mode_r == clti_pkg::MODE_READ) && ok_r) begin
          rdata_nxt = rd_val & byte_mask(nb_r);
        end
        step_nxt  = '0;
        state_nxt = clti_pkg::S_CMP;
      end

      clti_pkg::S_CMP: begin
        // Sweep the compares: issue hart step, compare the one issued before
        ram_addr = clti_pkg::HART_W'(step_r);
        if (step_r != '0) begin
          tirq_nxt[slot_r] = (timer_r >= cmp_eff);
        end
        slot_nxt = step_r[1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == clti_pkg::STEP_W'(clti_pkg::IRQ_HARTS)) begin
          state_nxt = clti_pkg::S_DONE;
        end
      end

      clti_pkg::S_DONE: begin
        // Hold until the output slot is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b000000, tirq_r, soft4, err_r, ok_r, rdata_r};
          state_nxt     = clti_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = clti_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clti_pkg::S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      timer_r     <= '0;
      soft_r      <= '0;
      cmp_valid_r <= '0;
      cfg_div_r   <= 16'd1;
      tirq_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      timer_r     <= timer_nxt;
      soft_r      <= soft_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      tirq_r      <= tirq_nxt;
      if (cfg_we) begin
        cfg_div_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r  <= in_tuser;
      off_r   <= in_tdata[15:0];
      nb_r    <= in_tdata[19:16];
      wdata_r <= in_tdata[83:20];
    end
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    rdata_r    <= rdata_nxt;
    ok_r       <= ok_nxt;
    err_r      <= err_nxt;
    src_r      <= src_nxt;
    slot_r     <= slot_nxt;
    rd_hart_r  <= ram_addr;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Assertions
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != clti_pkg::S_IDLE))
    else $error("accepted beat did not start work");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clti_pkg::S_DIV) |-> (rem_r < div_eff))
    else $error("divider remainder not below divisor");

  a_ok_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[64] && out_data_r[65]))
    else $error("read_ok and divisor_error both set");

  a_data_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[64] || (out_data_r[63:0] == 64'd0)))
    else $error("read data without read_ok");

endmodule

`default_nettype wire

>>> dv/tb_core_local_timer_interruptor_unit.sv
// ----------------------------------------------------------------------------
// tb_core_local_timer_interruptor_unit
// Self-checking bench for the core-local timer and software interrupt block.
// Tick, read and write beats go in on the in_ stream and every beat is
// predicted by a cycle-free model of the register map and the timer. Each
// beat on the out_ stream is checked field by field against the oldest
// prediction. Several phases change the tick divisor and the idle and stall
// pattern of both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_core_local_timer_interruptor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode code outside the defined set; the block must leave all state alone
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 60;
  // Cycles to hold after the last result before the verdict
  localparam int TAIL_CYCLES     = 60;
  // Limit for the whole run, well above what the slowest run takes
  localparam int RUN_LIMIT_NS    = 5_000_000;

  // One access beat as driven on in_
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] offset;
    logic [3:0]  nbytes;
    logic [63:0] wdata;
    logic [31:0] count;
  } access_beat_t;

  // One result beat as seen on out_
  typedef struct packed {
    logic [63:0] read_data;
    logic        read_ok;
    logic        div_err;
    logic [3:0]  soft_irq;
    logic [3:0]  timer_irq;
  } irq_result_t;

  // --------------------------------------------------------------------------
  // Register-map model and result scoreboard
  // --------------------------------------------------------------------------
  class clint_scoreboard;
    logic [63:0] mtime_q;
    logic [63:0] mtimecmp_q [clti_pkg::HARTS];
    logic        msip_q [clti_pkg::HARTS];
    logic [15:0] tick_div_q;
    irq_result_t awaited_results [$];
    int unsigned failures;

    function new();
      mtime_q    = '0;
      tick_div_q = 16'd1;
      failures   = 0;
      for (int h = 0; h < clti_pkg::HARTS; h++) begin
        mtimecmp_q[h] = '1;
        msip_q[h]     = 1'b0;
      end
    endfunction

    function void set_divisor(logic [15:0] d);
      tick_div_q = d;
    endfunction

    function logic [63:0] mtime_now();
      return mtime_q;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // Register read: returns the ok flag, data cut to the access length
    function bit read_register(input logic [15:0] off, input logic [3:0] nb,
                               output logic [63:0] data);
      logic [63:0] v;
      int          h;
      v    = '0;
      data = '0;
      if (off >= clti_pkg::MAP_END) return 1'b0;
      if (off < clti_pkg::SOFT_END) begin
        if (off[1:0] != 2'b00) return 1'b0;
        h = int'(off >> 2);
        if (h < clti_pkg::HARTS) v = {63'd0, msip_q[h]};
      end else if (off == clti_pkg::TIMER_OFF) begin
        v = mtime_q;
      end else begin
        if (off[2:0] != 3'b000) return 1'b0;
        h = int'((off - clti_pkg::SOFT_END) >> 3);
        if (h < clti_pkg::HARTS) v = mtimecmp_q[h];
      end
      if (nb >= 4'd8) data = v;
      else if (nb == 4'd0) data = '0;
      else data = v & ((64'd1 << (8 * nb)) - 64'd1);
      return 1'b1;
    endfunction

    function void write_register(logic [15:0] off, logic [3:0] nb, logic [63:0] d);
      int h;
      if (off >= clti_pkg::MAP_END) return;
      if (off < clti_pkg::SOFT_END) begin
        h = int'(off >> 2);
        if (off[1:0] == 2'b00 && nb >= 4'd4 && h < clti_pkg::HARTS) msip_q[h] = d[0];
        return;
      end
      // Timer and compare take only full, aligned 64-bit writes
      if (nb != 4'd8 || off[2:0] != 3'b000) return;
      if (off == clti_pkg::TIMER_OFF) begin
        mtime_q = d;
        return;
      end
      h = int'((off - clti_pkg::SOFT_END) >> 3);
      if (h < clti_pkg::HARTS) mtimecmp_q[h] = d;
    endfunction

    // Advance the model by one accepted beat and queue its result
    function void note_access(access_beat_t b);
      irq_result_t r;
      logic [31:0] div;
      r = '0;
      case (b.mode)
        clti_pkg::MODE_TICK: begin
          // A zero divisor counts as one
          div       = (tick_div_q == 16'd0) ? 32'd1 : {16'd0, tick_div_q};
          r.div_err = (b.count % div) != 32'd0;
          mtime_q   = mtime_q + {32'd0, b.count / div};
        end
        clti_pkg::MODE_READ:
          r.read_ok = read_register(b.offset, b.nbytes, r.read_data);
        clti_pkg::MODE_WRITE: write_register(b.offset, b.nbytes, b.wdata);
        default: ;
      endcase
      for (int h = 0; h < clti_pkg::IRQ_HARTS; h++) begin
        r.soft_irq[h]  = msip_q[h];
        r.timer_irq[h] = mtime_q >= mtimecmp_q[h];
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [79:0] beat);
      irq_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat 0x%0h with no access outstanding", beat);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("read_data",     want.read_data,         beat[63:0]);
      compare_field("read_ok",       {63'd0, want.read_ok},  {63'd0, beat[64]});
      compare_field("divisor_error", {63'd0, want.div_err},  {63'd0, beat[65]});
      compare_field("soft_irq",      {60'd0, want.soft_irq}, {60'd0, beat[69:66]});
      compare_field("timer_irq",     {60'd0, want.timer_irq}, {60'd0, beat[73:70]});
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and bus signals
  // --------------------------------------------------------------------------
  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;   // [1:0] mode
  // [15:0] offset, [19:16] access_bytes, [83:20] write_data,
  // [115:84] tick_count, [119:116] zero
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // [63:0] read_data, [64] read_ok, [65] divisor_error, [69:66] soft_irq,
  // [73:70] timer_irq, [79:74] zero
  logic [79:0]  out_tdata;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  core_local_timer_interruptor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  clint_scoreboard sb = new();

  // Percent of cycles in which the sender idles / the receiver stalls
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;

  // Receiver: drop tready at random, per cycle, at the falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every result beat taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("core_local_timer_interruptor_unit verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one access beat from the falling edge and hold it until taken
  task automatic send_access(logic [1:0] mode, logic [15:0] off, logic [3:0] nb,
                             logic [63:0] wd, logic [31:0] cnt);
    access_beat_t b;
    b = '{mode: mode, offset: off, nbytes: nb, wdata: wd, count: cnt};
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {4'd0, cnt, wd, nb, off};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_access(b);
  endtask

  // Drop the input, then reprogram the divisor once every result is drained
  task automatic program_divisor(logic [15:0] d);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = d;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_divisor(d);
  endtask

  task automatic set_idling(int unsigned pattern);
    case (pattern)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 56; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 56; end
      default: begin send_gap_pct = 6; stall_pct = 6; end
    endcase
  endtask

  // Mostly well-formed accesses to live registers, with some noise
  task automatic random_access();
    logic [1:0]  mode;
    logic [15:0] off;
    logic [3:0]  nb;
    logic [63:0] wd;
    logic [31:0] cnt;
    logic [31:0] div;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) mode = clti_pkg::MODE_TICK;
    else if (pick < 12) mode = clti_pkg::MODE_READ;
    else if (pick < 19) mode = clti_pkg::MODE_WRITE;
    else mode = MODE_NONE;

    case ($urandom_range(0, 9))
      0, 1: off = 16'(4 * $urandom_range(0, clti_pkg::HARTS));
      2:    off = 16'(4 * $urandom_range(0, clti_pkg::HARTS) + $urandom_range(1, 3));
      3, 4, 5: off = clti_pkg::SOFT_END + 16'(8 * $urandom_range(0, clti_pkg::HARTS));
      6, 7: off = clti_pkg::TIMER_OFF;
      8:    off = 16'($urandom);
      default: off = clti_pkg::MAP_END + 16'($urandom_range(0, 16'h3FFF));
    endcase

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: nb = 4'd8;
      5, 6: nb = 4'd4;
      default: nb = 4'($urandom_range(0, 15));
    endcase

    // Keep compares near the timer so the interrupt levels toggle
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: wd = sb.mtime_now() - 64'd2000 + 64'($urandom_range(0, 4000));
      5, 6, 7: wd = {$urandom, $urandom};
      8: wd = 64'd0 - 64'($urandom_range(0, 5000));
      default: wd = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase

    div = (sb.tick_div_q == 16'd0) ? 32'd1 : {16'd0, sb.tick_div_q};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: cnt = 32'($urandom_range(0, 3000));
      6, 7: cnt = div * 32'($urandom_range(0, 50));
      8: cnt = $urandom;
      default: cnt = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase

    send_access(mode, off, nb, wd, cnt);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [15:0] phase_divisor [PHASES];

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    out_tready = 1'b0;

    // Divisor per phase: reset value, both extremes, zero and a few in between
    phase_divisor = '{16'd1, 16'd65535, 16'd7, 16'd0,
                      16'($urandom_range(1, 65535)), 16'd2, 16'd3,
                      16'($urandom_range(1, 300))};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at divisor one with both streams running freely
    set_idling(0);
    program_divisor(16'd1);
    // timer after reset, then a compare at its reset value of all ones
    send_access(clti_pkg::MODE_READ,  clti_pkg::TIMER_OFF, 4'd8, '0, '0);
    send_access(clti_pkg::MODE_READ,  clti_pkg::SOFT_END,  4'd8, '0, '0);
    send_access(clti_pkg::MODE_WRITE, clti_pkg::SOFT_END,  4'd8, 64'd100, '0);
    // crosses compare 0
    send_access(clti_pkg::MODE_TICK,  16'h0000, 4'd0, '0, 32'd150);
    // short timer write
    send_access(clti_pkg::MODE_WRITE, clti_pkg::TIMER_OFF, 4'd4,  '0, '0);
    // length above eight, zero length, three bytes
    send_access(clti_pkg::MODE_READ,  clti_pkg::TIMER_OFF, 4'd15, '0, '0);
    send_access(clti_pkg::MODE_READ,  clti_pkg::TIMER_OFF, 4'd0,  '1, '0);
    send_access(clti_pkg::MODE_READ,  clti_pkg::TIMER_OFF, 4'd3,  '0, '0);
    send_access(clti_pkg::MODE_WRITE, 16'h0000, 4'd4, 64'd1, '0);
    send_access(clti_pkg::MODE_WRITE, 16'h000C, 4'd8, '1, '0);
    send_access(clti_pkg::MODE_WRITE, 16'h0004, 4'd2, 64'd1, '0);   // short soft write
    send_access(clti_pkg::MODE_WRITE, 16'h0006, 4'd4, 64'd1, '0);   // misaligned soft write
    send_access(clti_pkg::MODE_READ,  16'h0002, 4'd4, '0, '0);      // misaligned soft read
    // misaligned compare read
    send_access(clti_pkg::MODE_READ,  clti_pkg::SOFT_END + 16'd4, 4'd8, '0, '0);
    send_access(clti_pkg::MODE_READ,  16'h0010, 4'd4, '0, '0);      // hart past the last
    send_access(clti_pkg::MODE_READ,  clti_pkg::SOFT_END + 16'h20, 4'd8, '0, '0);
    send_access(clti_pkg::MODE_WRITE, clti_pkg::SOFT_END + 16'h20, 4'd8, 64'd0, '0);
    // beyond the map
    send_access(clti_pkg::MODE_READ,  clti_pkg::MAP_END, 4'd8, '0, '0);
    send_access(clti_pkg::MODE_WRITE, 16'hFFFF, 4'd8, '0, '0);
    // timer at all ones, then a tick that wraps it
    send_access(clti_pkg::MODE_WRITE, clti_pkg::TIMER_OFF, 4'd8, '1, '0);
    send_access(clti_pkg::MODE_TICK,  16'hFFFF, 4'd15, '1, '1);
    send_access(MODE_NONE,            16'hFFFF, 4'd15, '1, '1);     // unknown mode
    send_access(clti_pkg::MODE_WRITE, clti_pkg::SOFT_END + 16'h8, 4'd8, 64'd0, '0);
    send_access(clti_pkg::MODE_TICK,  16'h0000, 4'd0, '0, 32'd0);
    send_access(clti_pkg::MODE_READ,  16'h000C, 4'd4, '0, '0);

    // Random phases, each with its own divisor and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      program_divisor(phase_divisor[p]);
      set_idling(p % 4);
      for (int i = 0; i < BEATS_PER_PHASE; i++) random_access();
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    set_idling(0);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("core_local_timer_interruptor_unit verification clean");
    end else begin
      $display("core_local_timer_interruptor_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
